/* rtl/tsb_pkg.sv */
// Shared types and codes for the text screen buffer engine.
// Used by the top level; no dependencies.
package tsb_pkg;

  localparam int SIZE_W = 6;

  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_SCROLL = 3'd3;
  localparam logic [2:0] CMD_PLOT   = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  localparam logic [1:0] SHIFT_UP    = 2'd0;
  localparam logic [1:0] SHIFT_RIGHT = 2'd1;
  localparam logic [1:0] SHIFT_DOWN  = 2'd2;
  localparam logic [1:0] SHIFT_LEFT  = 2'd3;

  // Register select is paddr[2]
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [3:0] SEMI_NIBBLE = 4'h8;
  localparam logic [7:0] SEMI_BASE   = 8'h80;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [1:0] direction;
  } tsb_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] cursor_col;
    logic [4:0] cursor_row;
  } tsb_rsp_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_EXEC,
    ST_UPDATE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_EMIT
  } tsb_state_t;

endpackage

/* rtl/tsb_cell_ram.sv */
// Character cell store: one write port, one read port, registered read data.
// No dependencies.
module tsb_cell_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/text_screen_buffer_engine_core.sv */
// Top level of the text screen buffer engine: command sequencer, cursor,
// configuration registers and result register. Uses tsb_pkg and tsb_cell_ram.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------
//   command  | cmd_valid/cmd_stall | cmd (tsb_cmd_t)
//   result   | rsp_valid/rsp_stall | rsp (tsb_rsp_t)
//   config   | APB write/read      | pwdata/prdata, paddr[2:0]
//
// Each command passes an execute step and ends in an emit step; read and plot dot
// add an update step, clear writes each cell of the screen in use once, and
// scroll reads then writes each cell through the single cell address unit.
// After reset a wipe pass writes every cell once, before the first command is taken.
// A result still stalled holds the next command in its final step until transfer.
module text_screen_buffer_engine_core
  import tsb_pkg::*;
#(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  tsb_cmd_t    cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output tsb_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COLS_RST = (32 > MAX_COLS) ? MAX_COLS : 32;
  localparam int ROWS_RST = (24 > MAX_ROWS) ? MAX_ROWS : 24;

  tsb_state_t       state, state_next;
  tsb_cmd_t         op;
  logic [SIZE_W-1:0] cols, rows, cols_next, rows_next;
  logic [CW-1:0]    cur_col;
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    sx;
  logic [RW-1:0]    sy;
  logic [AW-1:0]    wipe_addr;
  logic [7:0]       rd_val;

  logic [SIZE_W-1:0] wm1, hm1, wsize, ux, uy, sat_x, sat_y;
  logic [CW-1:0]    tx, ax, src_x;
  logic [RW-1:0]    ty, ay, src_y;
  logic             is_clear, rev_x, rev_y;
  logic             x_first, x_lastpos, y_first, y_lastpos, x_end, y_end, vacated;
  logic [7:0]       qbit, plot_val;
  logic [AW-1:0]    cell_addr;
  logic             cfg_wr;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             load_rsp;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wsize  = pwdata[SIZE_W-1:0];
  assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows) : 32'(cols);

  always_comb begin
    cols_next = cols;
    rows_next = rows;
    if (cfg_wr && paddr[2] == REG_COLS) begin
      if (wsize == '0) cols_next = SIZE_W'(1);
      else if (7'(wsize) > 7'(MAX_COLS)) cols_next = SIZE_W'(MAX_COLS);
      else cols_next = wsize;
    end
    if (cfg_wr && paddr[2] == REG_ROWS) begin
      if (wsize == '0) rows_next = SIZE_W'(1);
      else if (7'(wsize) > 7'(MAX_ROWS)) rows_next = SIZE_W'(MAX_ROWS);
      else rows_next = wsize;
    end
  end

  // ---------------- coordinate and address unit ----------------
  assign wm1 = cols - SIZE_W'(1);
  assign hm1 = rows - SIZE_W'(1);

  assign ux    = (op.command == CMD_PLOT) ? {1'b0, op.pos_x[5:1]} : op.pos_x;
  assign uy    = (op.command == CMD_PLOT) ? {1'b0, op.pos_y[5:1]} : op.pos_y;
  assign sat_x = (ux >= cols) ? wm1 : ux;
  assign sat_y = (uy >= rows) ? hm1 : uy;
  assign tx    = CW'(sat_x);
  assign ty    = RW'(sat_y);

  assign qbit     = 8'h01 << {op.pos_y[0], op.pos_x[0]};
  assign plot_val = ((mem_rdata[7:4] == SEMI_NIBBLE) ? mem_rdata : SEMI_BASE) | qbit;

  assign is_clear  = (op.command == CMD_CLEAR);
  assign rev_x     = !is_clear && (op.direction == SHIFT_RIGHT);
  assign rev_y     = !is_clear && (op.direction == SHIFT_DOWN);
  assign x_first   = (sx == '0);
  assign y_first   = (sy == '0);
  assign x_lastpos = (SIZE_W'(sx) == wm1);
  assign y_lastpos = (SIZE_W'(sy) == hm1);
  assign x_end     = rev_x ? x_first : x_lastpos;
  assign y_end     = rev_y ? y_first : y_lastpos;

  // Source cell of the scroll, and whether the target is the vacated edge
  always_comb begin
    src_x = sx;
    src_y = sy;
    case (op.direction)
      SHIFT_UP: begin
        vacated = y_lastpos;
        if (!vacated) src_y = sy + RW'(1);
      end
      SHIFT_RIGHT: begin
        vacated = x_first;
        if (!vacated) src_x = sx - CW'(1);
      end
      SHIFT_DOWN: begin
        vacated = y_first;
        if (!vacated) src_y = sy - RW'(1);
      end
      default: begin
        vacated = x_lastpos;
        if (!vacated) src_x = sx + CW'(1);
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_EXEC: begin
        ax = (op.command == CMD_PUT) ? cur_col : tx;
        ay = (op.command == CMD_PUT) ? cur_row : ty;
      end
      ST_UPDATE: begin
        ax = tx;
        ay = ty;
      end
      ST_SWEEP_RD: begin
        ax = src_x;
        ay = src_y;
      end
      ST_SWEEP_WR: begin
        ax = sx;
        ay = sy;
      end
      default: begin
        ax = cur_col;
        ay = cur_row;
      end
    endcase
  end

  assign cell_addr = AW'(AW'(ay) * AW'(MAX_COLS)) + AW'(ax);

  tsb_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cell_addr),
    .rdata (mem_rdata)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_WIPE:     if (wipe_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (cmd_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (op.command)
          CMD_CLEAR:  state_next = ST_SWEEP_WR;
          CMD_SCROLL: state_next = ST_SWEEP_RD;
          CMD_PLOT:   state_next = ST_UPDATE;
          CMD_READ:   state_next = ST_UPDATE;
          default:    state_next = ST_EMIT;
        endcase
      end
      ST_UPDATE:   state_next = ST_EMIT;
      ST_SWEEP_RD: state_next = ST_SWEEP_WR;
      ST_SWEEP_WR: begin
        if (x_end && y_end) state_next = ST_EMIT;
        else if (is_clear) state_next = ST_SWEEP_WR;
        else state_next = ST_SWEEP_RD;
      end
      ST_EMIT:     if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default:     state_next = ST_WIPE;
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = '0;
    load_rsp  = 1'b0;
    case (state)
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_addr;
      end
      ST_IDLE: cmd_stall = 1'b0;
      ST_EXEC: begin
        mem_we    = (op.command == CMD_PUT);
        mem_wdata = op.char_code;
      end
      ST_UPDATE: begin
        mem_we    = (op.command == CMD_PLOT);
        mem_wdata = plot_val;
      end
      ST_SWEEP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (is_clear || vacated) ? 8'h00 : mem_rdata;
      end
      ST_EMIT: load_rsp = !rsp_valid || !rsp_stall;
      default: cmd_stall = 1'b1;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      wipe_addr <= '0;
      cols      <= SIZE_W'(COLS_RST);
      rows      <= SIZE_W'(ROWS_RST);
      cur_col   <= '0;
      cur_row   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cols  <= cols_next;
      rows  <= rows_next;
      if (state == ST_WIPE) wipe_addr <= wipe_addr + AW'(1);

      if (cfg_wr) begin
        // Pull the cursor back inside a shrunken screen
        if (SIZE_W'(cur_col) >= cols_next) cur_col <= CW'(cols_next - SIZE_W'(1));
        if (SIZE_W'(cur_row) >= rows_next) cur_row <= RW'(rows_next - SIZE_W'(1));
      end else if (state == ST_EXEC && op.command == CMD_SET) begin
        cur_col <= tx;
        cur_row <= ty;
      end else if (state == ST_EXEC && op.command == CMD_PUT) begin
        if (SIZE_W'(cur_col) < wm1) begin
          cur_col <= cur_col + CW'(1);
        end else if (SIZE_W'(cur_row) < hm1) begin
          cur_col <= '0;
          cur_row <= cur_row + RW'(1);
        end
      end

      if (load_rsp) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Payload and walk counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) op <= cmd;

    if (state == ST_EXEC) begin
      rd_val <= '0;
      sx     <= rev_x ? CW'(wm1) : '0;
      sy     <= rev_y ? RW'(hm1) : '0;
    end
    if (state == ST_UPDATE && op.command == CMD_READ) rd_val <= mem_rdata;

    if (state == ST_SWEEP_WR) begin
      if (!x_end) begin
        sx <= rev_x ? sx - CW'(1) : sx + CW'(1);
      end else begin
        // Wrap to the start of the next line of the walk
        sx <= rev_x ? CW'(wm1) : '0;
        sy <= rev_y ? sy - RW'(1) : sy + RW'(1);
      end
    end

    if (load_rsp) begin
      rsp.read_data  <= rd_val;
      rsp.cursor_col <= 5'(cur_col);
      rsp.cursor_row <= 5'(cur_row);
    end
  end

`ifndef ASSERT_OFF
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (SIZE_W'(cur_col) < cols) && (SIZE_W'(cur_row) < rows))
    else $error("cursor outside the screen in use");

  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside the emit step");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> state == ST_EXEC)
    else $error("accepted command did not start execution");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_IDLE && state != ST_EMIT && state != ST_SWEEP_RD))
    else $error("cell write outside a writing step");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_screen_buffer_engine_core: directed table, then random
// command streams over several screen sizes. Depends on tsb_pkg and the core RTL only.
module tb_top;
  import tsb_pkg::*;

  localparam int SCR_W = 32;
  localparam int SCR_H = 32;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {ROW_CMD, ROW_COLS, ROW_ROWS} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    tsb_cmd_t    c;
    logic        fixed;
    tsb_rsp_t    want;
    int unsigned value;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  tsb_cmd_t    cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  tsb_rsp_t    rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // sideband of the offered command: typed expectation for directed rows
  logic        fix_on = 1'b0;
  tsb_rsp_t    fix_rsp = '0;

  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0]  stall_pat = '0;
  logic [5:0]  pat_age = '0;

  // screen model
  logic [7:0]  cells [0:SCR_W*SCR_H-1];
  int unsigned cur_col, cur_row, cols_n, rows_n;

  tsb_rsp_t    rsp_due [$];
  plan_row_t   plan [$];
  int unsigned err_count = 0;
  int unsigned reg_err = 0;
  int unsigned burst_left = 0;

  text_screen_buffer_engine_core #(
    .MAX_COLS(SCR_W),
    .MAX_ROWS(SCR_H)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned sat_to(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    int unsigned m;
    m = v & 32'h3f;
    if (m < 1) return 1;
    if (m > maxv) return maxv;
    return m;
  endfunction

  function automatic void screen_resize(logic sel, int unsigned value);
    if (sel == REG_COLS) cols_n = clamp_dim(value, SCR_W);
    else rows_n = clamp_dim(value, SCR_H);
    cur_col = sat_to(cur_col, cols_n);
    cur_row = sat_to(cur_row, rows_n);
  endfunction

  // in-place sweep in the same order as the hardware definition
  function automatic void screen_scroll(logic [1:0] dir);
    int unsigned x, y, tx, ty;
    for (y = 0; y < rows_n; y++) begin
      for (x = 0; x < cols_n; x++) begin
        case (dir)
          SHIFT_UP: begin
            cells[y*SCR_W+x] = (y == rows_n - 1) ? 8'h00 : cells[(y+1)*SCR_W+x];
          end
          SHIFT_RIGHT: begin
            tx = cols_n - 1 - x;
            cells[y*SCR_W+tx] = (tx == 0) ? 8'h00 : cells[y*SCR_W+tx-1];
          end
          SHIFT_DOWN: begin
            ty = rows_n - 1 - y;
            cells[ty*SCR_W+x] = (ty == 0) ? 8'h00 : cells[(ty-1)*SCR_W+x];
          end
          default: begin
            cells[y*SCR_W+x] = (x == cols_n - 1) ? 8'h00 : cells[y*SCR_W+x+1];
          end
        endcase
      end
    end
  endfunction

  function automatic tsb_rsp_t screen_apply(tsb_cmd_t c);
    tsb_rsp_t    r;
    int unsigned cx, cy, x, y;
    logic [7:0]  old, dot;
    r = '0;
    case (c.command)
      CMD_PUT: begin
        cells[cur_row*SCR_W+cur_col] = c.char_code;
        if (cur_col < cols_n - 1) begin
          cur_col++;
        end else if (cur_row < rows_n - 1) begin
          cur_col = 0;
          cur_row++;
        end
      end
      CMD_SET: begin
        cur_col = sat_to(c.pos_x, cols_n);
        cur_row = sat_to(c.pos_y, rows_n);
      end
      CMD_CLEAR: begin
        for (y = 0; y < rows_n; y++)
          for (x = 0; x < cols_n; x++)
            cells[y*SCR_W+x] = 8'h00;
      end
      CMD_SCROLL: screen_scroll(c.direction);
      CMD_PLOT: begin
        cx = sat_to(c.pos_x >> 1, cols_n);
        cy = sat_to(c.pos_y >> 1, rows_n);
        old = cells[cy*SCR_W+cx];
        dot = 8'(1 << {c.pos_y[0], c.pos_x[0]});
        cells[cy*SCR_W+cx] = ((old[7:4] == SEMI_NIBBLE) ? old : SEMI_BASE) | dot;
      end
      CMD_READ: begin
        r.read_data = cells[sat_to(c.pos_y, rows_n)*SCR_W+sat_to(c.pos_x, cols_n)];
      end
      default: ;
    endcase
    r.cursor_col = cur_col[4:0];
    r.cursor_row = cur_row[4:0];
    return r;
  endfunction

  function automatic void plan_cmd(logic [2:0] op, logic [7:0] ch, logic [5:0] x,
                                   logic [5:0] y, logic [1:0] d, logic fixed,
                                   tsb_rsp_t want);
    plan_row_t p;
    p = '0;
    p.kind = ROW_CMD;
    p.c = {op, ch, x, y, d};
    p.fixed = fixed;
    p.want = want;
    plan.push_back(p);
  endfunction

  function automatic void plan_reg(row_kind_t kind, int unsigned value);
    plan_row_t p;
    p = '0;
    p.kind = kind;
    p.value = value;
    plan.push_back(p);
  endfunction

  function automatic tsb_cmd_t next_cmd();
    tsb_cmd_t    c;
    int unsigned pick, v;
    logic        roomy;
    roomy = (cols_n * rows_n > 64);
    pick = $urandom_range(0, 99);
    c.char_code = 8'($urandom);
    c.direction = 2'($urandom);
    if (roomy) begin
      if (pick < 35) c.command = CMD_PUT;
      else if (pick < 50) c.command = CMD_SET;
      else if (pick < 70) c.command = CMD_PLOT;
      else if (pick < 92) c.command = CMD_READ;
      else if (pick < 94) c.command = CMD_CLEAR;
      else if (pick < 98) c.command = CMD_SCROLL;
      else c.command = pick[0] ? CMD_SPARE7 : CMD_SPARE6;
    end else begin
      if (pick < 30) c.command = CMD_PUT;
      else if (pick < 42) c.command = CMD_SET;
      else if (pick < 60) c.command = CMD_PLOT;
      else if (pick < 78) c.command = CMD_READ;
      else if (pick < 82) c.command = CMD_CLEAR;
      else if (pick < 96) c.command = CMD_SCROLL;
      else c.command = pick[0] ? CMD_SPARE7 : CMD_SPARE6;
    end
    // mostly near the screen in use, sometimes anywhere in the field
    if ($urandom_range(0, 3) == 0) begin
      c.pos_x = 6'($urandom);
      c.pos_y = 6'($urandom);
    end else if (c.command == CMD_PLOT) begin
      v = $urandom_range(0, 2 * cols_n + 1);
      c.pos_x = (v > 63) ? 6'd63 : 6'(v);
      v = $urandom_range(0, 2 * rows_n + 1);
      c.pos_y = (v > 63) ? 6'd63 : 6'(v);
    end else begin
      c.pos_x = 6'($urandom_range(0, cols_n));
      c.pos_y = 6'($urandom_range(0, rows_n));
    end
    return c;
  endfunction

  task automatic offer(tsb_cmd_t c, logic fixed, tsb_rsp_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= c;
    fix_on <= fixed;
    fix_rsp <= want;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic sel, int unsigned value);
    int unsigned reg_want;
    drain();
    // let the sequencer settle back to idle after the last transfer
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    screen_resize(sel, value);
    reg_want = (sel == REG_COLS) ? cols_n : rows_n;
    // read the register back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_want) begin
      reg_err++;
      if (reg_err <= 10)
        $display("%0t: register read %0d/%0d (exp/act)", $time, reg_want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: long hold on request, otherwise a random stall pattern, renewed whenever pat_age wraps
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      pat_age <= pat_age + 1'b1;
      if (pat_age == '0) stall_pat <= ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      rsp_stall <= stall_pat[pat_age[2:0]];
    end
  end

  always @(posedge clk) begin
    tsb_rsp_t got, want, guess;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (rsp_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result with none outstanding: read_data %h col %0d row %0d",
                     $time, got.read_data, got.cursor_col, got.cursor_row);
        end else begin
          want = rsp_due.pop_front();
          if (got.read_data !== want.read_data || got.cursor_col !== want.cursor_col ||
              got.cursor_row !== want.cursor_row) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch read_data %h/%h col %0d/%0d row %0d/%0d (exp/act)",
                       $time, want.read_data, got.read_data, want.cursor_col,
                       got.cursor_col, want.cursor_row, got.cursor_row);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        guess = screen_apply(cmd);
        rsp_due.push_back(fix_on ? fix_rsp : guess);
      end
    end
  end

  initial begin
    int unsigned ph_cols [9] = '{4, 1, 32, 0, 63, 8, 32'hffff_ffc5, 3, 32};
    int unsigned ph_rows [9] = '{3, 1, 32, 40, 0, 8, 2, 7, 24};
    int unsigned ph_items [9] = '{150, 60, 90, 80, 60, 150, 120, 150, 90};
    plan_row_t   row;

    foreach (cells[i]) cells[i] = 8'h00;
    cur_col = 0;
    cur_row = 0;
    cols_n = 32;
    rows_n = 24;

    // directed rows on the reset screen (32 x 24)
    plan_cmd(CMD_READ,   8'h00,  0,  0, SHIFT_UP,    1, {8'h00,  5'd0,  5'd0});
    plan_cmd(CMD_READ,   8'h00, 63, 63, SHIFT_UP,    1, {8'h00,  5'd0,  5'd0});
    plan_cmd(CMD_PUT,    8'h41,  0,  0, SHIFT_UP,    1, {8'h00,  5'd1,  5'd0});
    plan_cmd(CMD_READ,   8'h00,  0,  0, SHIFT_UP,    1, {8'h41,  5'd1,  5'd0});
    plan_cmd(CMD_SET,    8'h00, 63, 63, SHIFT_UP,    1, {8'h00, 5'd31, 5'd23});
    plan_cmd(CMD_PUT,    8'hff,  0,  0, SHIFT_UP,    1, {8'h00, 5'd31, 5'd23});
    plan_cmd(CMD_READ,   8'h00, 63, 63, SHIFT_UP,    1, {8'hff, 5'd31, 5'd23});
    plan_cmd(CMD_SET,    8'h00, 31,  0, SHIFT_UP,    1, {8'h00, 5'd31,  5'd0});
    plan_cmd(CMD_PUT,    8'h00,  0,  0, SHIFT_UP,    1, {8'h00,  5'd0,  5'd1});
    plan_cmd(CMD_PLOT,   8'h00,  0,  0, SHIFT_UP,    0, '0);
    plan_cmd(CMD_PLOT,   8'h00,  1,  1, SHIFT_UP,    0, '0);
    plan_cmd(CMD_PLOT,   8'h00, 63, 63, SHIFT_UP,    0, '0);
    plan_cmd(CMD_READ,   8'h00,  0,  0, SHIFT_UP,    0, '0);
    plan_cmd(CMD_READ,   8'h00, 63, 63, SHIFT_UP,    0, '0);
    plan_cmd(CMD_SCROLL, 8'h00,  0,  0, SHIFT_RIGHT, 0, '0);
    plan_cmd(CMD_SCROLL, 8'h00,  0,  0, SHIFT_DOWN,  0, '0);
    plan_cmd(CMD_SCROLL, 8'h00,  0,  0, SHIFT_LEFT,  0, '0);
    plan_cmd(CMD_SCROLL, 8'h00,  0,  0, SHIFT_UP,    0, '0);
    plan_cmd(CMD_READ,   8'h00,  1,  1, SHIFT_UP,    0, '0);
    plan_cmd(CMD_SPARE6, 8'hff, 63, 63, SHIFT_LEFT,  0, '0);
    plan_cmd(CMD_SPARE7, 8'hff, 63, 63, SHIFT_LEFT,  0, '0);
    plan_cmd(CMD_CLEAR,  8'h00,  0,  0, SHIFT_UP,    0, '0);
    plan_cmd(CMD_READ,   8'h00, 63, 63, SHIFT_UP,    1, {8'h00,  5'd0,  5'd1});
    // zero columns counts as one, oversize rows as the maximum
    plan_reg(ROW_COLS, 0);
    plan_reg(ROW_ROWS, 63);
    plan_cmd(CMD_SET,    8'h00, 63, 63, SHIFT_UP,    1, {8'h00,  5'd0, 5'd31});
    plan_cmd(CMD_PUT,    8'h7e,  0,  0, SHIFT_UP,    1, {8'h00,  5'd0, 5'd31});
    plan_cmd(CMD_READ,   8'h00,  0, 63, SHIFT_UP,    1, {8'h7e,  5'd0, 5'd31});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_CMD:  offer(row.c, row.fixed, row.want);
        ROW_COLS: reg_write(REG_COLS, row.value);
        default:  reg_write(REG_ROWS, row.value);
      endcase
    end

    for (int p = 0; p < 9; p++) begin
      reg_write(REG_COLS, ph_cols[p]);
      reg_write(REG_ROWS, ph_rows[p]);
      // back up the result side while commands keep coming
      if (p == 5) hold_req <= ~hold_req;
      for (int n = 0; n < ph_items[p]; n++) begin
        if ($urandom_range(0, 79) == 0) drain();
        offer(next_cmd(), 1'b0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_count == 0 && reg_err == 0 && rsp_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
